FILE: rtl/ckc_pkg.sv
// ----------------------------------------------------------------------------
// ckc_pkg: shared types and constants of the C keyword counter
// Keyword table, report id coding and the structs passed between modules.
// ----------------------------------------------------------------------------
package ckc_pkg;

	// keyword set and report ids
	localparam int NUM_KW     = 32;
	localparam int NUM_IDS    = 33;
	localparam int ID_W       = 6;
	localparam int KW_IDX_W   = 5;
	localparam int KW_TEXT_W  = 64;
	localparam int KW_LEN_W   = 4;
	localparam int OCC_W      = 32;
	localparam int OUT_DATA_W = 40;

	// report id of the total counter, sorted between switch and typedef
	localparam logic [ID_W-1:0] TOTAL_ID = 6'd26;
	// one past the last report id
	localparam logic [ID_W-1:0] ID_END   = 6'd33;

	// keyword text, right-justified, first letter in the highest used byte
	localparam logic [KW_TEXT_W-1:0] KW_TEXT [NUM_KW] = '{
		64'("auto"),     64'("break"),    64'("case"),     64'("char"),
		64'("const"),    64'("continue"), 64'("default"),  64'("do"),
		64'("double"),   64'("else"),     64'("enum"),     64'("extern"),
		64'("float"),    64'("for"),      64'("goto"),     64'("if"),
		64'("int"),      64'("long"),     64'("register"), 64'("return"),
		64'("short"),    64'("signed"),   64'("sizeof"),   64'("static"),
		64'("struct"),   64'("switch"),   64'("typedef"),  64'("union"),
		64'("unsigned"), 64'("void"),     64'("volatile"), 64'("while")
	};

	localparam logic [KW_LEN_W-1:0] KW_LEN [NUM_KW] = '{
		4'd4, 4'd5, 4'd4, 4'd4, 4'd5, 4'd8, 4'd7, 4'd2,
		4'd6, 4'd4, 4'd4, 4'd6, 4'd5, 4'd3, 4'd4, 4'd2,
		4'd3, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd6, 4'd6,
		4'd6, 4'd6, 4'd7, 4'd5, 4'd8, 4'd4, 4'd8, 4'd5
	};

	// matched keyword leaving the word matcher
	typedef struct packed {
		logic                valid;
		logic [KW_IDX_W-1:0] idx;
	} kw_hit_t;

	// counter read issued by the report sequencer
	typedef struct packed {
		logic            valid;
		logic [ID_W-1:0] id;
	} scan_req_t;

	// report id to keyword memory index (total has no memory entry)
	function automatic logic [KW_IDX_W-1:0] id_to_idx(input logic [ID_W-1:0] id);
		logic [ID_W-1:0] adj;
		adj = (id < TOTAL_ID) ? id : id - 6'd1;
		return adj[KW_IDX_W-1:0];
	endfunction

endpackage

FILE: rtl/c_keyword_counter.sv
// ----------------------------------------------------------------------------
// c_keyword_counter: C89 keyword frequency counter
// Counts keywords in a stream of C source bytes and reports the counts.
// ----------------------------------------------------------------------------
// Input channel s_*: s_tdata carries one text byte, s_tuser is the end of
// stream flag. A data byte is taken every cycle while the block is idle.
// The keyword hit of a word is registered at the transfer that ends it; the
// counter memory is read in the next cycle and written back the cycle after.
// On an end of stream transfer the block stops taking input, waits until no
// counter update is pending, then walks the 33 report ids in order, skipping
// ids whose count is zero; each reported count is read from memory and then
// loaded into the output register. The walk stops after the last reported
// id; a stall on m_tready holds the output register and pauses the walk.
// The last report item carries m_tlast; after it is loaded all counters
// read zero and input resumes.
// An empty report sends nothing. Reset clears all counters at once through
// per-entry valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module c_keyword_counter #(
	parameter int COUNT_WIDTH  = 32,
	parameter int MAX_WORD_LEN = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,   // text_byte
	input  logic                              s_tuser,   // op
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [ckc_pkg::OUT_DATA_W-1:0]    m_tdata,   // keyword_id, occurrences
	output logic                              m_tlast    // last
);
	import ckc_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_DRAIN = 4'b0010,
		ST_SCAN  = 4'b0100,
		ST_WAIT  = 4'b1000
	} state_t;

	state_t                 state_q;
	logic [ID_W-1:0]        id_q;
	logic                   last_q;
	logic                   m_tvalid_q;
	logic [OUT_DATA_W-1:0]  m_tdata_q;
	logic                   m_tlast_q;

	logic                   in_xfer;
	logic                   byte_valid;
	logic                   eos;
	kw_hit_t                hit;
	scan_req_t              scan;
	logic                   clear;
	logic [COUNT_WIDTH-1:0] scan_data;
	logic [NUM_IDS-1:0]     nz;
	logic                   busy;
	logic                   out_free;
	logic                   id_nz;
	logic [NUM_IDS-1:0]     nz_above;
	logic [COUNT_WIDTH+OCC_W-1:0] cnt_ext;
	logic [OCC_W-1:0]       occ;

	// input transfer decode
	assign s_tready   = (state_q == ST_IDLE);
	assign in_xfer    = s_tvalid && s_tready;
	assign byte_valid = in_xfer && !s_tuser;
	assign eos        = in_xfer && s_tuser;

	// scan step
	assign out_free = !m_tvalid_q || m_tready;
	assign id_nz    = (id_q != ID_END) ? nz[id_q] : 1'b0;
	assign nz_above = nz >> (id_q + 6'd1);
	assign scan.valid = (state_q == ST_SCAN) && id_nz && out_free;
	assign scan.id    = id_q;
	assign clear = ((state_q == ST_SCAN) && (id_q == ID_END)) ||
	               ((state_q == ST_WAIT) && last_q);

	// count clipped to the reported width
	assign cnt_ext = {OCC_W'(0), scan_data};
	assign occ     = (|cnt_ext[COUNT_WIDTH+OCC_W-1:OCC_W]) ? '1 : cnt_ext[OCC_W-1:0];

	ckc_word_match #(
		.MAX_WORD_LEN(MAX_WORD_LEN)
	) u_word (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.eos       (eos),
		.text_byte (s_tdata),
		.hit       (hit)
	);

	ckc_count_store #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.hit      (hit),
		.scan     (scan),
		.clear    (clear),
		.scan_data(scan_data),
		.nz       (nz),
		.busy     (busy)
	);

	// report sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			id_q    <= '0;
			last_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (eos) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!busy) begin
						id_q    <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (id_q == ID_END) begin
						state_q <= ST_IDLE;
					end else if (!id_nz) begin
						id_q <= id_q + 6'd1;
					end else if (out_free) begin
						last_q  <= ~|nz_above;
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (last_q) begin
						state_q <= ST_IDLE;
					end else begin
						id_q    <= id_q + 6'd1;
						state_q <= ST_SCAN;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_WAIT) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (state_q == ST_WAIT) begin
			m_tdata_q <= {(OUT_DATA_W-OCC_W-ID_W)'(0), occ, id_q};
			m_tlast_q <= last_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

`ifndef NO_ASSERTIONS
	// the output register is free whenever a count is loaded
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WAIT |-> !m_tvalid_q)
		else $error("output register overwritten");

	// counts are only read once the increment path has drained
	a_scan_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> !busy)
		else $error("report scan with increment in flight");

	// a loaded report item belongs to a nonzero counter
	a_load_nz: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WAIT |-> $past(state_q) == ST_SCAN && $past(id_nz))
		else $error("report item without a preceding counter read");
`endif

endmodule

FILE: rtl/ckc_word_match.sv
// ----------------------------------------------------------------------------
// ckc_word_match: word assembly and keyword compare
// Collects runs of letters and, when a word ends, registers the keyword hit.
// ----------------------------------------------------------------------------
module ckc_word_match #(
	parameter int MAX_WORD_LEN = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             byte_valid,
	input  logic             eos,
	input  logic [7:0]       text_byte,
	output ckc_pkg::kw_hit_t hit
);
	import ckc_pkg::*;

	localparam int WORD_W = MAX_WORD_LEN * 8;
	localparam int LEN_W  = $clog2(MAX_WORD_LEN + 1);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_WORD_LEN);

	logic [WORD_W-1:0]   word_q;
	logic [LEN_W-1:0]    len_q;
	logic                too_long_q;
	logic                letter;
	logic                in_word;
	logic                word_end;
	logic                match_any;
	logic [KW_IDX_W-1:0] match_idx;

	// byte classification
	assign letter   = (text_byte >= 8'h41 && text_byte <= 8'h5a) ||
	                  (text_byte >= 8'h61 && text_byte <= 8'h7a);
	assign in_word  = (len_q != '0);
	assign word_end = (byte_valid && !letter) || eos;

	// compare the last letters with every keyword, at most one matches
	always_comb begin
		match_any = 1'b0;
		match_idx = '0;
		for (int k = 0; k < NUM_KW; k++) begin
			if (word_q[KW_TEXT_W-1:0] == KW_TEXT[k] && len_q == LEN_W'(KW_LEN[k])) begin
				match_any = 1'b1;
				match_idx = match_idx | KW_IDX_W'(k);
			end
		end
	end

	// letter buffer, zero-filled at word start so short words compare directly
	always_ff @(posedge clk) begin
		if (byte_valid && letter && len_q != LEN_MAX) begin
			if (in_word) begin
				word_q <= {word_q[WORD_W-9:0], text_byte};
			end else begin
				word_q <= {(WORD_W-8)'(0), text_byte};
			end
		end
	end

	// word length, overflow flag and registered hit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			too_long_q <= 1'b0;
			hit        <= '0;
		end else begin
			hit.valid <= word_end && in_word && !too_long_q && match_any;
			hit.idx   <= match_idx;
			if (word_end) begin
				len_q      <= '0;
				too_long_q <= 1'b0;
			end else if (byte_valid && letter) begin
				if (len_q != LEN_MAX) begin
					len_q <= len_q + LEN_W'(1);
				end else begin
					too_long_q <= 1'b1;
				end
			end
		end
	end

endmodule

FILE: rtl/ckc_count_store.sv
// ----------------------------------------------------------------------------
// ckc_count_store: keyword counter memory and total counter
// Read-modify-write of saturating counters, read port for the report scan.
// ----------------------------------------------------------------------------
module ckc_count_store #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ckc_pkg::kw_hit_t           hit,
	input  ckc_pkg::scan_req_t         scan,
	input  logic                       clear,
	output logic [COUNT_WIDTH-1:0]     scan_data,
	output logic [ckc_pkg::NUM_IDS-1:0] nz,
	output logic                       busy
);
	import ckc_pkg::*;

	logic [COUNT_WIDTH-1:0] mem [NUM_KW];
	logic [NUM_KW-1:0]      valid_q;
	logic [COUNT_WIDTH-1:0] total_q;

	logic [KW_IDX_W-1:0]    rd_addr;
	logic                   hit_s2;
	logic [KW_IDX_W-1:0]    idx_s2;
	logic [COUNT_WIDTH-1:0] rd_s2;
	logic                   vld_s2;
	logic                   fwd_s2;
	logic [COUNT_WIDTH-1:0] fwd_data_s2;
	logic                   total_sel_s2;
	logic [COUNT_WIDTH-1:0] cur_cnt;
	logic [COUNT_WIDTH-1:0] next_cnt;

	// one read port, shared by the increment path and the report scan
	assign rd_addr = scan.valid ? id_to_idx(scan.id) : hit.idx;

	// current value: forwarded write, memory data, or zero for a fresh entry
	assign cur_cnt  = fwd_s2 ? fwd_data_s2 : (vld_s2 ? rd_s2 : '0);
	assign next_cnt = (&cur_cnt) ? cur_cnt : cur_cnt + COUNT_WIDTH'(1);

	assign scan_data = total_sel_s2 ? total_q : cur_cnt;
	assign busy      = hit.valid || hit_s2;
	assign nz        = {valid_q[NUM_KW-1:26], |total_q, valid_q[25:0]};

	// counter memory, synchronous read
	always_ff @(posedge clk) begin
		if (hit_s2) begin
			mem[idx_s2] <= next_cnt;
		end
		rd_s2 <= mem[rd_addr];
	end

	// payload of the second stage
	always_ff @(posedge clk) begin
		idx_s2      <= rd_addr;
		fwd_data_s2 <= next_cnt;
	end

	// control of the second stage, entry valid bits and total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s2       <= 1'b0;
			vld_s2       <= 1'b0;
			fwd_s2       <= 1'b0;
			total_sel_s2 <= 1'b0;
			valid_q      <= '0;
			total_q      <= '0;
		end else begin
			hit_s2       <= hit.valid;
			vld_s2       <= valid_q[rd_addr];
			fwd_s2       <= hit_s2 && (idx_s2 == rd_addr);
			total_sel_s2 <= scan.valid && (scan.id == TOTAL_ID);
			if (clear) begin
				valid_q <= '0;
				total_q <= '0;
			end else if (hit_s2) begin
				valid_q[idx_s2] <= 1'b1;
				if (!(&total_q)) begin
					total_q <= total_q + COUNT_WIDTH'(1);
				end
			end
		end
	end

`ifndef NO_ASSERTIONS
	// the scan never overlaps an increment in flight
	a_scan_excl: assert property (@(posedge clk) disable iff (!arst_n)
		scan.valid |-> !hit.valid && !hit_s2)
		else $error("scan read while an increment is in flight");

	// clearing only happens once the increment path is empty
	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		clear |-> !hit_s2)
		else $error("counter clear during a write");

	// a written entry reads back nonzero on the next cycle
	a_wr_nz: assert property (@(posedge clk) disable iff (!arst_n)
		hit_s2 && !clear |=> valid_q[$past(idx_s2)] && (total_q != '0))
		else $error("written counter not marked nonzero");
`endif

endmodule

FILE: tb/c_keyword_counter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// c_keyword_counter_tb: self-checking bench for the C keyword counter
// Feeds C-like text with keywords, odd words and raw bytes, flushes at random
// points and checks every reported count against a keyword-counting model of
// the block. Counters are built 8 bits wide here.
// ----------------------------------------------------------------------------
module c_keyword_counter_tb;

	import ckc_pkg::*;

	localparam int CNT_W      = 8;
	localparam int MAX_WORD   = 8;
	localparam int IDLE_LIMIT = 4000;
	localparam int RAND_ITEMS = 236;

	localparam bit OP_DATA  = 1'b0;
	localparam bit OP_FLUSH = 1'b1;

	localparam logic [ID_W-1:0] KW_DO       = 6'd7;
	localparam logic [ID_W-1:0] KW_VOLATILE = 6'd31;

	typedef struct packed {
		bit [ID_W-1:0]  id;
		bit [OCC_W-1:0] occ;
		bit             last;
	} report_t;

	// one directed transfer, with its typed-in report where one is given
	typedef struct packed {
		bit            op;
		bit [7:0]      text;
		bit            typed;
		bit [1:0]      n_exp;
		report_t [2:0] exp;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata = 8'h00;   // text_byte
	logic                  s_tuser = 1'b0;    // op
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;           // keyword_id, occurrences
	logic                  m_tlast;           // last

	// keyword spelling in report id order, total left out
	string kw_names [NUM_KW] = '{
		"auto", "break", "case", "char", "const", "continue", "default", "do",
		"double", "else", "enum", "extern", "float", "for", "goto", "if",
		"int", "long", "register", "return", "short", "signed", "sizeof",
		"static", "struct", "switch", "typedef", "union", "unsigned", "void",
		"volatile", "while"
	};

	// model state of the word scanner and the counters
	bit [7:0]       word_buf [MAX_WORD];
	int             word_len = 0;
	bit             word_long = 1'b0;
	bit             in_word = 1'b0;
	bit [CNT_W-1:0] kw_counts [NUM_IDS];

	report_t flush_reports [$];
	report_t pending_reports [$];

	dir_row_t directed [24];

	int  errors = 0;
	int  idle_cycles = 0;
	int  fed = 0;
	int  stall_left = 0;
	bit  steady_send = 1'b0;
	bit  steady_recv = 1'b0;

	c_keyword_counter #(
		.COUNT_WIDTH  (CNT_W),
		.MAX_WORD_LEN (MAX_WORD)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic report_t rep(bit [ID_W-1:0] id, bit [OCC_W-1:0] occ, bit last);
		report_t r;
		r.id = id;
		r.occ = occ;
		r.last = last;
		return r;
	endfunction

	// append one report to the list of those still to arrive
	function automatic void queue_report(report_t r);
		pending_reports = {pending_reports, r};
	endfunction

	function automatic bit is_letter(bit [7:0] b);
		return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
	endfunction

	function automatic void bump(int id);
		if (kw_counts[id] != {CNT_W{1'b1}})
			kw_counts[id]++;
	endfunction

	// match the finished word against the keyword list
	function automatic void close_word();
		bit matched;
		bit same;
		if (in_word && !word_long) begin
			matched = 1'b0;
			for (int k = 0; k < NUM_KW; k++) begin
				if (!matched && kw_names[k].len() == word_len) begin
					same = 1'b1;
					for (int i = 0; i < word_len; i++)
						if (kw_names[k][i] != word_buf[i])
							same = 1'b0;
					if (same) begin
						matched = 1'b1;
						bump(k < int'(TOTAL_ID) ? k : k + 1);
						bump(TOTAL_ID);
					end
				end
			end
		end
		word_len = 0;
		word_long = 1'b0;
		in_word = 1'b0;
	endfunction

	// advance the model by one transfer; a flush fills flush_reports
	function automatic void count_keywords(bit op, bit [7:0] b);
		bit [63:0] v;
		flush_reports.delete();
		if (op == OP_DATA) begin
			if (is_letter(b)) begin
				if (word_len < MAX_WORD) begin
					word_buf[word_len] = b;
					word_len++;
				end else begin
					word_long = 1'b1;
				end
				in_word = 1'b1;
			end else begin
				close_word();
			end
		end else begin
			close_word();
			for (int id = 0; id < NUM_IDS; id++) begin
				v = 64'(kw_counts[id]);
				if (v != 0)
					flush_reports = {flush_reports,
						rep(ID_W'(id), v > 64'hFFFF_FFFF ? '1 : v[31:0], 1'b0)};
				kw_counts[id] = '0;
			end
			if (flush_reports.size() > 0)
				flush_reports[flush_reports.size() - 1].last = 1'b1;
		end
	endfunction

	function automatic int send_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady_send || r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 30);
	endfunction

	function automatic int recv_stall();
		int r;
		r = $urandom_range(0, 99);
		if (steady_recv || r < 65)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 30);
	endfunction

	task automatic mismatch(string what);
		$display("mismatch at %0t: %s", $time, what);
		errors++;
	endtask

	// present one item and hold it until the transfer
	task automatic drive_item(bit op, bit [7:0] b);
		int gap;
		gap = send_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic expect_flush();
		foreach (flush_reports[i])
			queue_report(flush_reports[i]);
	endtask

	task automatic put(bit op, bit [7:0] b);
		drive_item(op, b);
		count_keywords(op, b);
		expect_flush();
		fed++;
	endtask

	task automatic put_word(string w);
		for (int i = 0; i < w.len(); i++)
			put(OP_DATA, w[i]);
	endtask

	// hold the sender until the whole report has drained
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_reports.size() != 0)
			@(posedge clk);
	endtask

	task automatic put_separator();
		bit [7:0] b;
		do b = 8'($urandom_range(0, 255)); while (is_letter(b));
		put(OP_DATA, b);
	endtask

	// report side: check each transfer, then pick the next ready level
	always @(posedge clk) begin
		report_t want;
		if (m_tvalid && m_tready) begin
			if (pending_reports.size() == 0) begin
				mismatch($sformatf("unexpected report id %0d count %0d last %0b",
					m_tdata[5:0], m_tdata[37:6], m_tlast));
			end else begin
				want = pending_reports.pop_front();
				if (m_tdata[5:0] != want.id)
					mismatch($sformatf("keyword id %0d, want %0d", m_tdata[5:0], want.id));
				if (m_tdata[37:6] != want.occ)
					mismatch($sformatf("count %0d for id %0d, want %0d",
						m_tdata[37:6], want.id, want.occ));
				if (m_tlast != want.last)
					mismatch($sformatf("tlast %0b for id %0d, want %0b",
						m_tlast, want.id, want.last));
			end
		end
		if ($urandom_range(0, 299) == 0)
			steady_recv = !steady_recv;
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready <= 1'b1;
			stall_left = recv_stall();
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		int r;
		int k;
		int len;
		string w;
		bit [7:0] b;

		// reset flush, a word cut by byte 255, a long word, a word cut by
		// byte 128, a word of the maximum length ended by the flush itself
		directed = '{
			'{OP_FLUSH, 8'h00, 1'b1, 2'd0, '0},
			'{OP_DATA,  "d",   1'b0, 2'd0, '0},
			'{OP_DATA,  "o",   1'b0, 2'd0, '0},
			'{OP_DATA,  8'hFF, 1'b0, 2'd0, '0},
			'{OP_DATA,  "v",   1'b0, 2'd0, '0},
			'{OP_DATA,  "o",   1'b0, 2'd0, '0},
			'{OP_DATA,  "l",   1'b0, 2'd0, '0},
			'{OP_DATA,  "a",   1'b0, 2'd0, '0},
			'{OP_DATA,  "t",   1'b0, 2'd0, '0},
			'{OP_DATA,  "i",   1'b0, 2'd0, '0},
			'{OP_DATA,  "l",   1'b0, 2'd0, '0},
			'{OP_DATA,  "e",   1'b0, 2'd0, '0},
			'{OP_DATA,  "Z",   1'b0, 2'd0, '0},
			'{OP_DATA,  8'h80, 1'b0, 2'd0, '0},
			'{OP_DATA,  "v",   1'b0, 2'd0, '0},
			'{OP_DATA,  "o",   1'b0, 2'd0, '0},
			'{OP_DATA,  "l",   1'b0, 2'd0, '0},
			'{OP_DATA,  "a",   1'b0, 2'd0, '0},
			'{OP_DATA,  "t",   1'b0, 2'd0, '0},
			'{OP_DATA,  "i",   1'b0, 2'd0, '0},
			'{OP_DATA,  "l",   1'b0, 2'd0, '0},
			'{OP_DATA,  "e",   1'b0, 2'd0, '0},
			'{OP_FLUSH, "x",   1'b1, 2'd3,
				{rep(KW_VOLATILE, 1, 1'b1), rep(TOTAL_ID, 2, 1'b0), rep(KW_DO, 1, 1'b0)}},
			'{OP_FLUSH, 8'h00, 1'b1, 2'd0, '0}
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (directed[i]) begin
			drive_item(directed[i].op, directed[i].text);
			count_keywords(directed[i].op, directed[i].text);
			if (directed[i].typed) begin
				for (int j = 0; j < directed[i].n_exp; j++)
					queue_report(directed[i].exp[j]);
			end else begin
				expect_flush();
			end
		end
		drain();

		// random text: mostly keywords, some odd words, raw bytes, flushes
		fed = 0;
		while (fed < RAND_ITEMS) begin
			if ($urandom_range(0, 19) == 0)
				steady_send = !steady_send;
			r = $urandom_range(0, 99);
			if (r < 55) begin
				k = $urandom_range(0, NUM_KW - 1);
				w = kw_names[k];
				if ($urandom_range(0, 9) == 0) begin
					len = $urandom_range(0, w.len() - 1);
					w[len] = w[len] ^ 8'h20;
				end
				put_word(w);
				if ($urandom_range(0, 9) != 0)
					put_separator();
			end else if (r < 70) begin
				len = $urandom_range(1, 12);
				for (int i = 0; i < len; i++) begin
					b = 8'($urandom_range(0, 51));
					put(OP_DATA, b < 26 ? "A" + b : "a" + (b - 26));
				end
				put_separator();
			end else if (r < 93) begin
				put(OP_DATA, 8'($urandom_range(0, 255)));
			end else begin
				put(OP_FLUSH, 8'($urandom_range(0, 255)));
				if ($urandom_range(0, 2) == 0)
					drain();
			end
		end
		put(OP_FLUSH, 8'($urandom_range(0, 255)));
		s_tvalid <= 1'b0;

		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);

		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

FILE: c_keyword_counter.f
rtl/ckc_pkg.sv
rtl/ckc_word_match.sv
rtl/ckc_count_store.sv
rtl/c_keyword_counter.sv
tb/c_keyword_counter_tb.sv
